### rtl/core/spc_pkg.sv
package spc_pkg;

  // Storage geometry.
  localparam int DEVICES   = 2;
  localparam int COEFS     = 41;
  localparam int RAM_DEPTH = COEFS * DEVICES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int DATA_W    = 64;
  localparam int FRAC_W    = 32;
  localparam int CIDX_W    = 6;
  localparam int F_NUM     = 6;
  localparam int FIDX_W    = 3;
  localparam int CNT_W     = 3;
  localparam int STEP_W    = 5;
  localparam int STEPS     = 21;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  // Coefficient slots inside one device's block.
  localparam logic [CIDX_W-1:0] A_IDX    = 6'd0;
  localparam logic [CIDX_W-1:0] ROW_TOP  = 6'd36;
  localparam logic [CIDX_W-1:0] TEMP_TOP = 6'd40;
  localparam logic [FIDX_W-1:0] F_TOP    = 3'd5;

  // Jump targets in the control program.
  localparam logic [STEP_W-1:0] STEP_ROW    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_ROW_MAC = 5'd2;
  localparam logic [STEP_W-1:0] STEP_P_MAC  = 5'd8;
  localparam logic [STEP_W-1:0] STEP_T_MAC  = 5'd17;
  localparam logic [STEP_W-1:0] LAST_STEP   = 5'd20;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LDACC,
    OP_MLO,
    OP_MHI,
    OP_ADD,
    OP_STF,
    OP_STP,
    OP_DONE
  } op_t;

  typedef enum logic {
    SRC_RAM,
    SRC_F
  } src_t;

  typedef enum logic {
    X_T,
    X_P
  } xsel_t;

  typedef enum logic [1:0] {
    J_NONE,
    J_CNT,
    J_FIDX
  } jmp_t;

  // One control word of the program.
  typedef struct packed {
    op_t               op;
    src_t              src;
    xsel_t             xsel;
    logic              cdec;
    logic              cld;
    logic [CIDX_W-1:0] cval;
    logic              fdec;
    logic              fld;
    logic [FIDX_W-1:0] fval;
    logic              nld;
    logic [CNT_W-1:0]  nval;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    op_t               op;
    src_t              src;
    xsel_t             xsel;
    logic [FIDX_W-1:0] fidx;
    logic [CIDX_W-1:0] cidx;
  } dp_ctrl_t;

  // Coefficient RAM address of one slot of one device.
  function automatic logic [RAM_AW-1:0] coef_addr(input logic dev,
                                                  input logic [CIDX_W-1:0] idx);
    logic [RAM_AW-1:0] base;
    base = dev ? RAM_AW'(COEFS) : '0;
    return base + RAM_AW'(idx);
  endfunction

  // Control program. Rows run from row six down to row one, so the
  // coefficient index walks down through the row block without gaps.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w        = '0;
    w.op     = OP_NOP;
    w.src    = SRC_RAM;
    w.xsel   = X_T;
    w.jmp    = J_NONE;
    unique case (step)
      // Row loop: load the term counter, then the top coefficient.
      5'd0: begin
        w.nld  = 1'b1;
        w.nval = 3'd4;
      end
      5'd1: begin
        w.op   = OP_LDACC;
        w.cdec = 1'b1;
      end
      5'd2: w.op = OP_MLO;
      5'd3: w.op = OP_MHI;
      5'd4: begin
        w.op     = OP_ADD;
        w.cdec   = 1'b1;
        w.jmp    = J_CNT;
        w.target = STEP_ROW_MAC;
      end
      5'd5: begin
        w.op     = OP_STF;
        w.fdec   = 1'b1;
        w.jmp    = J_FIDX;
        w.target = STEP_ROW;
      end
      // Pressure polynomial over the row results.
      5'd6: begin
        w.fld  = 1'b1;
        w.fval = F_TOP;
        w.nld  = 1'b1;
        w.nval = 3'd4;
        w.cld  = 1'b1;
        w.cval = A_IDX;
      end
      5'd7: begin
        w.op   = OP_LDACC;
        w.src  = SRC_F;
        w.fdec = 1'b1;
      end
      5'd8: begin
        w.op   = OP_MLO;
        w.xsel = X_P;
      end
      5'd9: begin
        w.op   = OP_MHI;
        w.xsel = X_P;
      end
      5'd10: begin
        w.op     = OP_ADD;
        w.src    = SRC_F;
        w.fdec   = 1'b1;
        w.jmp    = J_CNT;
        w.target = STEP_P_MAC;
      end
      5'd11: begin
        w.op   = OP_MLO;
        w.xsel = X_P;
      end
      5'd12: begin
        w.op   = OP_MHI;
        w.xsel = X_P;
      end
      5'd13: w.op = OP_ADD;
      // Park the pressure, then the cubic temperature polynomial.
      5'd14: begin
        w.op   = OP_STP;
        w.cld  = 1'b1;
        w.cval = TEMP_TOP;
        w.nld  = 1'b1;
        w.nval = 3'd2;
      end
      5'd15: w.op = OP_NOP;
      5'd16: begin
        w.op   = OP_LDACC;
        w.cdec = 1'b1;
      end
      5'd17: w.op = OP_MLO;
      5'd18: w.op = OP_MHI;
      5'd19: begin
        w.op     = OP_ADD;
        w.cdec   = 1'b1;
        w.jmp    = J_CNT;
        w.target = STEP_T_MAC;
      end
      5'd20: w.op = OP_DONE;
      default: w.op = OP_DONE;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/spc_ram.sv
module spc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 82
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/spc_seq.sv
module spc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               hold,
  output spc_pkg::dp_ctrl_t  ctrl,
  output logic               busy,
  output logic               done
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [spc_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [spc_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [spc_pkg::CIDX_W-1:0]        cidx_r, cidx_nxt;
  logic [spc_pkg::FIDX_W-1:0]        fidx_r, fidx_nxt;
  spc_pkg::uword_t                   uw;

  // Fetch the control word of the current step.
  always_comb begin
    uw = spc_pkg::ucode(step_r);
  end

  // Step counter, index registers and jumps.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    cidx_nxt  = cidx_r;
    fidx_nxt  = fidx_r;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          step_nxt  = spc_pkg::STEP_ROW;
          cidx_nxt  = spc_pkg::ROW_TOP;
          fidx_nxt  = spc_pkg::F_TOP;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (uw.cdec) begin
          cidx_nxt = cidx_r - 1'b1;
        end
        if (uw.cld) begin
          cidx_nxt = uw.cval;
        end
        if (uw.fdec) begin
          fidx_nxt = fidx_r - 1'b1;
        end
        if (uw.fld) begin
          fidx_nxt = uw.fval;
        end
        if (uw.nld) begin
          cnt_nxt = uw.nval;
        end
        unique case (uw.jmp)
          spc_pkg::J_CNT: begin
            if (cnt_r != '0) begin
              cnt_nxt  = cnt_r - 1'b1;
              step_nxt = uw.target;
            end
          end
          spc_pkg::J_FIDX: begin
            if (fidx_r != '0) begin
              step_nxt = uw.target;
            end
          end
          default: begin
          end
        endcase
        // The last step waits while the previous result is still stalled.
        if (uw.op == spc_pkg::OP_DONE) begin
          if (hold) begin
            step_nxt = step_r;
          end else begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      cidx_r  <= '0;
      fidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      cidx_r  <= cidx_nxt;
      fidx_r  <= fidx_nxt;
    end
  end

  // Datapath control; the datapath idles while the sequencer does.
  always_comb begin
    ctrl.op   = (state_r == S_RUN) ? uw.op : spc_pkg::OP_NOP;
    ctrl.src  = uw.src;
    ctrl.xsel = uw.xsel;
    ctrl.fidx = fidx_r;
    ctrl.cidx = cidx_r;
  end

  assign busy = (state_r == S_RUN);

  // The step counter never runs past the end of the program.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> step_r <= spc_pkg::LAST_STEP)
    else $error("step counter ran past the program");

  // A result is never finished while the output register is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !hold)
    else $error("result finished over a stalled output");

  // Row results are only addressed inside the row register file.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && uw.src == spc_pkg::SRC_F &&
     (uw.op == spc_pkg::OP_ADD || uw.op == spc_pkg::OP_LDACC)) ||
    (state_r == S_RUN && uw.op == spc_pkg::OP_STF)
    |-> fidx_r <= spc_pkg::F_TOP)
    else $error("row result index out of range");

endmodule

### rtl/core/spc_dp.sv
module spc_dp (
  input  logic                        clk,
  input  spc_pkg::dp_ctrl_t           ctrl,
  input  logic                        start,
  input  logic [spc_pkg::FRAC_W-1:0]  t_frac,
  input  logic [spc_pkg::FRAC_W-1:0]  p_frac,
  input  logic [spc_pkg::DATA_W-1:0]  ram_q,
  output logic [spc_pkg::DATA_W-1:0]  pres,
  output logic [spc_pkg::DATA_W-1:0]  temp,
  output logic                        sat
);

  logic [spc_pkg::DATA_W-1:0]  acc_r;
  logic [spc_pkg::DATA_W-1:0]  prod_r;
  logic [spc_pkg::FRAC_W-1:0]  lo_r;
  logic [spc_pkg::DATA_W-1:0]  pres_r;
  logic                        sat_r;
  logic [spc_pkg::DATA_W-1:0]  f_r [spc_pkg::F_NUM];

  logic [spc_pkg::DATA_W-1:0]  operand;
  logic [spc_pkg::FRAC_W-1:0]  x;
  logic signed [spc_pkg::FRAC_W:0]     mul_a;
  logic signed [spc_pkg::FRAC_W:0]     mul_b;
  logic signed [2*spc_pkg::FRAC_W+1:0] mul_p;
  logic [spc_pkg::DATA_W-1:0]  sum;
  logic                        ovf;
  logic [spc_pkg::DATA_W-1:0]  sat_sum;

  // Operand select: a stored coefficient or a row result.
  always_comb begin
    operand = (ctrl.src == spc_pkg::SRC_F) ? f_r[ctrl.fidx] : ram_q;
    x       = (ctrl.xsel == spc_pkg::X_P) ? p_frac : t_frac;
  end

  // Shared 33x32 multiplier: low half of the accumulator first (unsigned),
  // then the high half (signed).
  always_comb begin
    if (ctrl.op == spc_pkg::OP_MHI) begin
      mul_a = $signed({acc_r[spc_pkg::DATA_W-1], acc_r[spc_pkg::DATA_W-1:spc_pkg::FRAC_W]});
    end else begin
      mul_a = $signed({1'b0, acc_r[spc_pkg::FRAC_W-1:0]});
    end
    mul_b = $signed({1'b0, x});
    mul_p = mul_a * mul_b;
  end

  // Saturating add of the operand and the truncated product.
  always_comb begin
    sum = operand + prod_r;
    ovf = (operand[spc_pkg::DATA_W-1] == prod_r[spc_pkg::DATA_W-1]) &&
          (sum[spc_pkg::DATA_W-1] != operand[spc_pkg::DATA_W-1]);
    if (ovf) begin
      sat_sum = operand[spc_pkg::DATA_W-1] ? spc_pkg::SAT_MIN : spc_pkg::SAT_MAX;
    end else begin
      sat_sum = sum;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      spc_pkg::OP_LDACC: acc_r <= operand;
      spc_pkg::OP_MLO:   lo_r <= mul_p[2*spc_pkg::FRAC_W-1:spc_pkg::FRAC_W];
      spc_pkg::OP_MHI:   prod_r <= mul_p[spc_pkg::DATA_W-1:0] +
                                   {{(spc_pkg::DATA_W-spc_pkg::FRAC_W){1'b0}}, lo_r};
      spc_pkg::OP_ADD:   acc_r <= sat_sum;
      spc_pkg::OP_STF:   f_r[ctrl.fidx] <= acc_r;
      spc_pkg::OP_STP:   pres_r <= acc_r;
      spc_pkg::OP_NOP,
      spc_pkg::OP_DONE: begin
      end
    endcase
    // Saturation flag covers one measurement.
    if (start) begin
      sat_r <= 1'b0;
    end else if (ctrl.op == spc_pkg::OP_ADD) begin
      sat_r <= sat_r | ovf;
    end
  end

  assign pres = pres_r;
  assign temp = acc_r;
  assign sat  = sat_r;

endmodule

### rtl/core/sensor_poly_compensation_core.sv
// Temperature-compensated pressure polynomial for up to DEVICES transducers.
// Input channel (in_valid / in_stall): a transaction either loads one signed
// Q31.32 coefficient (kind 0, slot 0..40 of one device) or starts a
// measurement (kind 1) from raw 24-bit pressure and 16-bit temperature codes;
// temperature_new replaces the held temperature of that device first.
// Loads and items for a device out of range give no result.
// A measurement gives one result transaction on the output channel
// (out_valid / out_stall) from the output register when its program ends;
// the input channel stalls while the program runs, so the next input is
// taken only once the result is finished. The run time is set by the single
// 33x32 multiplier shared by all 39 multiply-adds (low partial product, high
// partial product, saturating add each) and the setup and store steps.
// The result sits in an output register: the block takes the next input while
// it waits, and only holds its last program step while the receiver stalls.
// Reset clears the held temperatures, the sequencer and the output valid; the
// coefficient memory keeps no reset value and must be loaded before use.
module sensor_poly_compensation_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic                in_device,
  input  logic [5:0]          in_coef_index,
  input  logic signed [63:0]  in_coef_value,
  input  logic [23:0]         in_pressure_raw,
  input  logic [15:0]         in_temperature_raw,
  input  logic                in_temperature_new,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_device,
  output logic signed [63:0]  out_pressure_out,
  output logic signed [63:0]  out_temperature_out,
  output logic                out_saturated
);

  logic                              in_acc;
  logic                              dev_ok;
  logic                              ram_we;
  logic                              start;
  logic                              busy;
  logic                              done;
  logic                              hold;
  spc_pkg::dp_ctrl_t                 ctrl;
  logic [spc_pkg::RAM_AW-1:0]        waddr;
  logic [spc_pkg::RAM_AW-1:0]        raddr;
  logic [spc_pkg::DATA_W-1:0]        ram_q;
  logic [spc_pkg::DATA_W-1:0]        pres;
  logic [spc_pkg::DATA_W-1:0]        temp;
  logic                              sat;
  logic [15:0]                       t_sel;

  logic [15:0]                       held_r [spc_pkg::DEVICES];
  logic                              dev_r;
  logic [spc_pkg::FRAC_W-1:0]        t_r;
  logic [spc_pkg::FRAC_W-1:0]        p_r;
  logic                              out_valid_r;
  logic                              out_device_r;
  logic [spc_pkg::DATA_W-1:0]        out_pres_r;
  logic [spc_pkg::DATA_W-1:0]        out_temp_r;
  logic                              out_sat_r;

  // Input transaction decode.
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign dev_ok   = (int'(in_device) < spc_pkg::DEVICES);
  assign ram_we   = in_acc && (in_kind == spc_pkg::KIND_LOAD) && dev_ok &&
                    (int'(in_coef_index) < spc_pkg::COEFS);
  assign start    = in_acc && (in_kind == spc_pkg::KIND_MEAS) && dev_ok;
  assign t_sel    = in_temperature_new ? in_temperature_raw : held_r[in_device];
  assign waddr    = spc_pkg::coef_addr(in_device, in_coef_index);
  assign raddr    = spc_pkg::coef_addr(dev_r, ctrl.cidx);
  assign hold     = out_valid_r && out_stall;

  // Held temperature per device.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spc_pkg::DEVICES; i++) begin
        held_r[i] <= '0;
      end
    end else if (start && in_temperature_new) begin
      held_r[in_device] <= in_temperature_raw;
    end
  end

  // Measurement operands, normalized to unsigned Q0.32 fractions.
  always_ff @(posedge clk) begin
    if (start) begin
      dev_r <= in_device;
      t_r   <= {t_sel, t_sel};
      p_r   <= {in_pressure_raw, in_pressure_raw[23:16]};
    end
  end

  spc_ram #(
    .WIDTH (spc_pkg::DATA_W),
    .DEPTH (spc_pkg::RAM_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_coef_value),
    .raddr (raddr),
    .rdata (ram_q)
  );

  spc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  spc_dp u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .start  (start),
    .t_frac (t_r),
    .p_frac (p_r),
    .ram_q  (ram_q),
    .pres   (pres),
    .temp   (temp),
    .sat    (sat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_device_r <= dev_r;
      out_pres_r   <= pres;
      out_temp_r   <= temp;
      out_sat_r    <= sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_device          = out_device_r;
  assign out_pressure_out    = out_pres_r;
  assign out_temperature_out = out_temp_r;
  assign out_saturated       = out_sat_r;

  // A finished measurement shows up on the output with its own device.
  assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid && out_device == $past(dev_r))
    else $error("finished result not presented");

  // A measurement start always puts the sequencer to work.
  assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("measurement accepted but sequencer idle");

endmodule

### test/tb_top.sv
module tb_top;
  import spc_pkg::*;

  // One compensated reading as the block reports it.
  typedef struct {
    logic               dev;
    logic signed [63:0] pressure;
    logic signed [63:0] temperature;
    logic               sat;
  } reading_t;

  // Tracks the coefficient banks and held temperatures, computes the reading
  // each measurement must produce and checks readings in order.
  class pressure_compensator;
    logic signed [63:0] coef_bank[DEVICES][COEFS];
    logic [15:0]        held_traw[DEVICES];
    logic               clipped;
    reading_t           pending_readings[$];
    int                 errors;

    function new();
      foreach (coef_bank[d, i]) coef_bank[d][i] = '0;
      foreach (held_traw[d]) held_traw[d] = '0;
      clipped = 1'b0;
      errors  = 0;
    endfunction

    // Q31.32 value times an unsigned Q0.32 fraction, low bits dropped.
    function logic signed [63:0] frac_mul(logic signed [63:0] a, logic [31:0] x);
      logic signed [96:0] prod;
      prod = a * $signed({1'b0, x});
      return prod[95:32];
    endfunction

    // Signed add that clips to the Q31.32 range and flags the clip.
    function logic signed [63:0] sum_clip(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        clipped = 1'b1;
        return a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
    endfunction

    // terms[0] + x*(terms[1] + x*(... + x*terms[n-1])).
    function logic signed [63:0] horner(logic signed [63:0] terms[$], logic [31:0] x);
      logic signed [63:0] acc;
      int                 i;
      acc = terms[terms.size() - 1];
      for (i = terms.size() - 2; i >= 0; i--) acc = sum_clip(terms[i], frac_mul(acc, x));
      return acc;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Notes one accepted input transaction.
    function void take_item(logic kind, logic dev, logic [5:0] idx, logic signed [63:0] val,
                            logic [23:0] praw, logic [15:0] traw, logic tnew);
      logic signed [63:0] row[$];
      logic signed [63:0] f_terms[$];
      logic signed [63:0] g_terms[$];
      logic [31:0]        p;
      logic [31:0]        t;
      reading_t           r;
      int                 k;
      int                 j;
      if (kind == KIND_LOAD) begin
        if (idx < COEFS) coef_bank[dev][idx] = val;
        return;
      end
      if (tnew) held_traw[dev] = traw;
      clipped = 1'b0;
      p = {praw, praw[23:16]};
      t = {held_traw[dev], held_traw[dev]};
      // Each row is a quintic in temperature.
      for (k = 0; k < 6; k++) begin
        row.delete();
        for (j = 0; j < 6; j++) row.push_back(coef_bank[dev][1 + 6 * k + j]);
        f_terms.push_back(horner(row, t));
      end
      for (j = 37; j <= 40; j++) g_terms.push_back(coef_bank[dev][j]);
      r.dev         = dev;
      r.pressure    = sum_clip(coef_bank[dev][0], frac_mul(horner(f_terms, p), p));
      r.temperature = horner(g_terms, t);
      r.sat         = clipped;
      pending_readings.push_back(r);
    endfunction

    // Compares one accepted result transaction with the oldest expected reading.
    function void check_reading(logic dev, logic signed [63:0] pres,
                                logic signed [63:0] temp, logic sat);
      reading_t e;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected reading: dev %0d pressure %h temperature %h sat %0d",
                   dev, pres, temp, sat);
        return;
      end
      e = pending_readings.pop_front();
      if (e.dev !== dev || e.pressure !== pres || e.temperature !== temp || e.sat !== sat) begin
        errors++;
        if (errors <= 10) begin
          $display("Reading mismatch at %0t:", $time);
          $display("  expected dev %0d pressure %h temperature %h sat %0d",
                   e.dev, e.pressure, e.temperature, e.sat);
          $display("  actual   dev %0d pressure %h temperature %h sat %0d",
                   dev, pres, temp, sat);
        end
      end
    endfunction

    // Readings still owed at the end count as failures.
    function void close_out();
      if (pending_readings.size() != 0) begin
        errors += pending_readings.size();
        $display("%0d readings never arrived", pending_readings.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_LOAD;
  logic               in_device = 1'b0;
  logic [5:0]         in_coef_index = '0;
  logic signed [63:0] in_coef_value = '0;
  logic [23:0]        in_pressure_raw = '0;
  logic [15:0]        in_temperature_raw = '0;
  logic               in_temperature_new = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_device;
  logic signed [63:0] out_pressure_out;
  logic signed [63:0] out_temperature_out;
  logic               out_saturated;

  pressure_compensator model = new();

  // Long receiver hold-offs requested by the stimulus and served by the sink.
  int unsigned hold_requests = 0;
  bit          quiet_in = 1'b0;
  int unsigned items = 0;

  sensor_poly_compensation_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_device           (in_device),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .in_pressure_raw     (in_pressure_raw),
    .in_temperature_raw  (in_temperature_raw),
    .in_temperature_new  (in_temperature_new),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_device          (out_device),
    .out_pressure_out    (out_pressure_out),
    .out_temperature_out (out_temperature_out),
    .out_saturated       (out_saturated)
  );

  always #4 clk = ~clk;

  // Idle run length: mostly short, a few long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    else if (pick < 96) return $urandom_range(4, 20);
    else return $urandom_range(50, 300);
  endfunction

  // Coefficient value; tame ones keep the polynomials clear of the rails.
  function automatic logic signed [63:0] rand_coef(bit wild);
    logic [63:0] raw;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    pick = wild ? $urandom_range(0, 99) : $urandom_range(0, 69);
    if (pick < 50) return {{30{raw[33]}}, raw[33:0]};
    else if (pick < 70) return {{16{raw[47]}}, raw[47:0]};
    else if (pick < 88) return raw;
    else if (pick < 94) return SAT_MAX;
    else return SAT_MIN;
  endfunction

  // Offers one input transaction and notes it once accepted.
  task automatic offer(input logic kind, input logic dev, input logic [5:0] idx,
                       input logic signed [63:0] val, input logic [23:0] praw,
                       input logic [15:0] traw, input logic tnew);
    int unsigned gap;
    gap = (quiet_in || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_device          <= dev;
    in_coef_index      <= idx;
    in_coef_value      <= val;
    in_pressure_raw    <= praw;
    in_temperature_raw <= traw;
    in_temperature_new <= tnew;
    do @(posedge clk); while (in_stall);
    model.take_item(kind, dev, idx, val, praw, traw, tnew);
  endtask

  // Loads ignore the raw fields, so those carry noise.
  task automatic load_coef(input logic dev, input logic [5:0] idx, input logic signed [63:0] val);
    offer(KIND_LOAD, dev, idx, val, 24'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Measurements ignore the coefficient fields, so those carry noise.
  task automatic measure(input logic dev, input logic [23:0] praw, input logic [15:0] traw,
                         input logic tnew);
    offer(KIND_MEAS, dev, 6'($urandom), {$urandom, $urandom}, praw, traw, tnew);
  endtask

  task automatic load_device(input logic dev, input bit wild);
    int i;
    for (i = 0; i < COEFS; i++) load_coef(dev, 6'(i), rand_coef(wild));
  endtask

  task automatic random_measure();
    logic [23:0] praw;
    logic [15:0] traw;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    praw = (pick == 0) ? 24'h0 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
    pick = $urandom_range(0, 9);
    traw = (pick == 0) ? 16'h0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    measure(1'($urandom), praw, traw, 1'($urandom));
  endtask

  // Stops offering until every expected reading has come back; in_valid always
  // drops before the next offer.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.pending() > 0);
  endtask

  // Stimulus: full coefficient load, directed corners, then random traffic.
  initial begin : stimulus
    int unsigned pick;
    int unsigned waited;
    bit          held_once;
    bit          drained_once;
    int          i;
    held_once    = 1'b0;
    drained_once = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every slot is written before any measurement reads it.
    load_device(1'b0, 1'b0);
    load_device(1'b1, 1'b0);

    // Held temperature is still zero from reset.
    measure(1'b0, 24'h0, 16'hFFFF, 1'b0);
    measure(1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1);
    measure(1'b1, 24'h800000, 16'h0, 1'b0);
    measure(1'b0, 24'hFFFFFF, 16'h0, 1'b1);
    measure(1'b0, 24'h000001, 16'h0001, 1'b1);
    // Loads past the last slot change nothing.
    load_coef(1'b0, 6'd41, SAT_MAX);
    load_coef(1'b0, 6'd63, SAT_MIN);
    measure(1'b0, 24'hFFFFFF, 16'hFFFF, 1'b1);
    // Drive the sums into the positive and then the negative rail.
    load_coef(1'b0, A_IDX, SAT_MAX);
    load_coef(1'b0, 6'd1, SAT_MAX);
    load_coef(1'b0, 6'd37, SAT_MAX);
    load_coef(1'b0, 6'd38, SAT_MAX);
    measure(1'b0, 24'hFFFFFF, 16'hFFFF, 1'b1);
    load_coef(1'b0, A_IDX, SAT_MIN);
    load_coef(1'b0, 6'd1, SAT_MIN);
    load_coef(1'b0, 6'd37, SAT_MIN);
    load_coef(1'b0, 6'd38, SAT_MIN);
    measure(1'b0, 24'hFFFFFF, 16'hFFFF, 1'b1);
    load_coef(1'b1, TEMP_TOP, SAT_MIN);
    load_coef(1'b1, ROW_TOP, SAT_MAX);
    measure(1'b1, 24'hFFFFFF, 16'h8000, 1'b1);

    // Random traffic, mostly measurements between coefficient updates.
    while (items < 1700) begin
      quiet_in = ((items / 150) % 4 == 2);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        random_measure();
        items++;
      end else if (pick < 86) begin
        load_coef(1'($urandom), 6'($urandom_range(0, 40)), rand_coef($urandom_range(0, 4) == 0));
        items++;
      end else if (pick < 92) begin
        load_coef(1'($urandom), 6'($urandom_range(41, 63)), rand_coef(1'b1));
      end else if (pick < 94) begin
        load_device(1'($urandom), $urandom_range(0, 2) == 0);
        items += COEFS;
      end else begin
        random_measure();
        items++;
      end

      // Back-to-back measurements against a long receiver hold-off.
      if (!held_once && items >= 600) begin
        held_once = 1'b1;
        hold_requests++;
        quiet_in = 1'b1;
        for (i = 0; i < 8; i++) random_measure();
        items += 8;
      end
      if (!drained_once && items >= 1200) begin
        drained_once = 1'b1;
        drain();
      end
    end

    // Wait for the last readings, then a little past the block's latency.
    in_valid <= 1'b0;
    waited = 0;
    while (model.pending() > 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    model.close_out();
    if (model.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result sink: checks accepted transactions and drives out_stall.
  initial begin : result_sink
    int unsigned stall_run;
    int unsigned calm_run;
    int unsigned served;
    int unsigned pick;
    stall_run = 0;
    calm_run  = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0)
        model.check_reading(out_device, out_pressure_out, out_temperature_out, out_saturated);
      if (served != hold_requests) begin
        served    = hold_requests;
        stall_run = 600;
        calm_run  = 0;
      end else if (stall_run == 0 && calm_run == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) calm_run = $urandom_range(1, 8);
        else if (pick < 60) calm_run = $urandom_range(100, 500);
        else stall_run = idle_len();
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if (calm_run > 0) calm_run--;
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sensor_poly_compensation_core.f
rtl/core/spc_pkg.sv
rtl/core/spc_ram.sv
rtl/core/spc_seq.sv
rtl/core/spc_dp.sv
rtl/core/sensor_poly_compensation_core.sv
test/tb_top.sv
